>>> hdl/mlt_pkg.sv
// Shared types and codes of the MPLS label table.
`default_nettype none

package mlt_pkg;

  // Default number of table entries
  localparam int unsigned TableDepthDefault = 256;

  // Field widths fixed by the interface
  localparam int unsigned OpW     = 2;
  localparam int unsigned FecW    = 32;
  localparam int unsigned LabelW  = 20;
  localparam int unsigned IfW     = 8;
  localparam int unsigned OptW    = 8;
  localparam int unsigned AssignW = 8;

  // Operation codes
  localparam logic [OpW-1:0] OP_INSTALL = 2'd0;
  localparam logic [OpW-1:0] OP_FEC     = 2'd1;
  localparam logic [OpW-1:0] OP_LABEL   = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // One stored table entry
  typedef struct packed {
    logic [FecW-1:0]   fec;
    logic [LabelW-1:0] out_label;
    logic [IfW-1:0]    in_if;
    logic [IfW-1:0]    out_if;
    logic [OptW-1:0]   optcode;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/mpls_label_table.sv
// Top level of the MPLS label table: sequencer, entry count and result registers.
`default_nettype none

// MPLS label table. A transfer is taken when start_i is high and busy_o is low;
// each request gives exactly one result, shown for one cycle with done_o high,
// and the receiver cannot stall it. Install and an unused opcode finish at once:
// the result appears the cycle after start and busy_o never rises. A label
// resolve reads one entry; the RAM read data and then the result are
// registered. A FEC resolve walks the installed entries in insertion order,
// one per cycle through the single read port of the entry RAM, and stops at
// the first match or after the last installed entry. The table needs no
// clearing after reset: only installed entries are ever used.
module mpls_label_table #(
  parameter int unsigned TABLE_DEPTH = mlt_pkg::TableDepthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [mlt_pkg::OpW-1:0]    opcode_i,
  input  wire logic [mlt_pkg::FecW-1:0]   fec_value_i,
  input  wire logic [mlt_pkg::LabelW-1:0] in_label_i,
  input  wire logic [mlt_pkg::IfW-1:0]    in_interface_i,
  input  wire logic [mlt_pkg::LabelW-1:0] new_out_label_i,
  input  wire logic [mlt_pkg::IfW-1:0]    new_out_interface_i,
  input  wire logic [mlt_pkg::OptW-1:0]   new_optcode_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [mlt_pkg::AssignW-1:0]     assigned_label_o,
  output logic [mlt_pkg::LabelW-1:0]      out_label_o,
  output logic [mlt_pkg::IfW-1:0]         out_interface_o,
  output logic [mlt_pkg::OptW-1:0]        result_optcode_o
);

  import mlt_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = AW + 1;
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_LABEL = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [CntW-1:0] idx_nxt;
  logic [FecW-1:0] key_q;
  logic [IfW-1:0]  iif_q;

  logic            accept;
  logic            we;
  logic [AW-1:0]   raddr;
  entry_t          wentry;
  entry_t          rentry;

  logic              fin;
  status_e           res_status;
  logic [AssignW-1:0] res_assigned;
  logic [LabelW-1:0] res_olabel;
  logic [IfW-1:0]    res_oif;
  logic [OptW-1:0]   res_opc;

  logic              done_q;
  status_e           status_q;
  logic [AssignW-1:0] assigned_q;
  logic [LabelW-1:0] olabel_q;
  logic [IfW-1:0]    oif_q;
  logic [OptW-1:0]   opc_q;

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign idx_nxt = CntW'(idx_q) + CntW'(1);

  // Entry written on install
  assign wentry.fec       = fec_value_i;
  assign wentry.out_label = new_out_label_i;
  assign wentry.in_if     = in_interface_i;
  assign wentry.out_if    = new_out_interface_i;
  assign wentry.optcode   = new_optcode_i;

  mlt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(wentry),
    .raddr_i(raddr),
    .rdata_o(rentry)
  );

  // Sequence one request: decide, issue reads, walk the table
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    we           = 1'b0;
    raddr        = idx_nxt[AW-1:0];
    fin          = 1'b0;
    res_status   = ST_NOT_FOUND;
    res_assigned = '0;
    res_olabel   = '0;
    res_oif      = '0;
    res_opc      = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_INSTALL: begin
              fin = 1'b1;
              if (cnt_q == CntFull) begin
                res_status = ST_FULL;
              end else begin
                we           = 1'b1;
                cnt_d        = cnt_q + CntW'(1);
                res_status   = ST_OK;
                res_assigned = AssignW'(cnt_q);
              end
            end
            OP_FEC: begin
              if (cnt_q == '0) begin
                fin = 1'b1;
              end else begin
                raddr   = '0;
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            OP_LABEL: begin
              if (in_label_i >= LabelW'(cnt_q)) begin
                fin = 1'b1;
              end else begin
                raddr   = in_label_i[AW-1:0];
                state_d = S_LABEL;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rentry.fec == key_q) begin
          fin        = 1'b1;
          res_status = ST_OK;
          res_olabel = rentry.out_label;
          res_oif    = rentry.out_if;
          state_d    = S_IDLE;
        end else if (idx_nxt == cnt_q) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_nxt[AW-1:0];
        end
      end
      S_LABEL: begin
        fin     = 1'b1;
        state_d = S_IDLE;
        if (rentry.in_if == iif_q) begin
          res_status = ST_OK;
          res_olabel = rentry.out_label;
          res_oif    = rentry.out_if;
          res_opc    = rentry.optcode;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      done_q  <= fin;
    end
  end

  // Hold the lookup keys of the request in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= fec_value_i;
      iif_q <= in_interface_i;
    end
  end

  // Capture the result for its one-cycle transfer
  always_ff @(posedge clk_i) begin
    if (fin) begin
      status_q   <= res_status;
      assigned_q <= res_assigned;
      olabel_q   <= res_olabel;
      oif_q      <= res_oif;
      opc_q      <= res_opc;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign assigned_label_o = assigned_q;
  assign out_label_o      = olabel_q;
  assign out_interface_o  = oif_q;
  assign result_optcode_o = opc_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("entry count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CntW'(idx_q) < cnt_q))
    else $error("FEC scan index past installed entries");

  a_install_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OP_INSTALL && cnt_q != CntFull)
      |=> (cnt_q == $past(cnt_q) + CntW'(1)) && done_q && status_q == ST_OK)
    else $error("install did not append an entry");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> (cnt_q == CntFull))
    else $error("table full reported with room left");

  a_lookup_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(cnt_q))
    else $error("entry count changed during a lookup");
`endif

endmodule

`default_nettype wire

>>> hdl/mlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
